[src/efi_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efi_pkg
// Shared types, constants and microcode program of the escape-time iterator.
// ----------------------------------------------------------------------------
package efi_pkg;

   localparam int WORD_BITS = 64;
   localparam int HALF_BITS = 32;
   localparam int ACC_BITS  = 128;
   localparam int UPC_BITS  = 5;

   // configuration register indexes
   typedef logic [2:0] csr_addr_type;
   localparam csr_addr_type CSR_MODE     = 3'd0;
   localparam csr_addr_type CSR_JULIA_RE = 3'd1;
   localparam csr_addr_type CSR_JULIA_IM = 3'd2;
   localparam csr_addr_type CSR_CAP      = 3'd3;
   localparam csr_addr_type CSR_LIMIT    = 3'd4;

   localparam int CAP_BITS   = 20;
   localparam int LIMIT_BITS = 16;

   localparam logic                  MODE_MANDELBROT = 1'b0;
   localparam logic                  MODE_JULIA      = 1'b1;
   localparam logic                  MODE_RESET      = MODE_JULIA;
   localparam logic [WORD_BITS-1:0]  JULIA_RE_RESET  = 64'd70369355297587;
   localparam logic [WORD_BITS-1:0]  JULIA_IM_RESET  = 64'd323653965;
   localparam logic [CAP_BITS-1:0]   CAP_RESET       = 20'd200000;
   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET     = 16'd16384;

   localparam logic [WORD_BITS-1:0] S64_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
   localparam logic [WORD_BITS-1:0] S64_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};

   typedef logic [UPC_BITS-1:0] upc_type;

   // program addresses used as jump targets
   localparam upc_type UPC_IDLE = 5'd0;
   localparam upc_type UPC_ABS  = 5'd1;
   localparam upc_type UPC_DONE = 5'd24;

   typedef enum logic {
      MUL_AX,
      MUL_AY
   } mul_sel_type;

   typedef enum logic [1:0] {
      PP_SH0,
      PP_SH32,
      PP_SH64
   } pp_shift_type;

   typedef enum logic [1:0] {
      BASE_ZERO,
      BASE_ACC,
      BASE_CX,
      BASE_CY
   } acc_base_type;

   typedef enum logic [2:0] {
      TERM_NONE,
      TERM_PP,
      TERM_XX,
      TERM_YY,
      TERM_NEG_YY
   } acc_term_type;

   typedef enum logic [2:0] {
      WB_NONE,
      WB_ABS,
      WB_XX,
      WB_YY,
      WB_X,
      WB_Y,
      WB_CNT
   } wb_type;

   typedef enum logic [2:0] {
      JMP_NEXT,
      JMP_ALWAYS,
      JMP_REQ,
      JMP_ESC,
      JMP_CAP,
      JMP_OUT
   } jmp_cond_type;

   typedef struct packed {
      mul_sel_type  mul_a;
      logic         mul_a_hi;
      mul_sel_type  mul_b;
      logic         mul_b_hi;
      pp_shift_type pp_shift;
      logic         pp_xy_sign;
      acc_base_type acc_base;
      acc_term_type acc_term;
      wb_type       wb;
      logic         iter_set;
      jmp_cond_type cond;
      upc_type      target;
   } ucode_word_type;

   typedef struct packed {
      logic req_valid;
      logic out_free;
      logic esc_hit;
      logic cap_hit;
   } seq_status_type;

   function automatic ucode_word_type uw(
      input mul_sel_type  a,
      input logic         ah,
      input mul_sel_type  b,
      input logic         bh,
      input pp_shift_type sh,
      input logic         sgn,
      input acc_base_type base,
      input acc_term_type term,
      input wb_type       wb,
      input logic         iter,
      input jmp_cond_type cond,
      input upc_type      tgt
   );
      ucode_word_type w;
      w = '{a, ah, b, bh, sh, sgn, base, term, wb, iter, cond, tgt};
      return w;
   endfunction

   // control store: multiply issued in one step is accumulated in the next
   function automatic ucode_word_type ucode_rom(input upc_type pc);
      ucode_word_type w;
      case (pc)
         5'd0:  w = uw(MUL_AX, 1'b0, MUL_AX, 1'b0, PP_SH0,  1'b0, BASE_ACC,  TERM_NONE,
                      WB_NONE, 1'b0, JMP_REQ, UPC_ABS);
         5'd1:  w = uw(MUL_AX, 1'b0, MUL_AX, 1'b0, PP_SH0,  1'b0, BASE_ACC,  TERM_NONE,
                      WB_ABS,  1'b0, JMP_NEXT, UPC_IDLE);
         // |x|^2
         5'd2:  w = uw(MUL_AX, 1'b0, MUL_AX, 1'b0, PP_SH0,  1'b0, BASE_ACC,  TERM_NONE,
                      WB_NONE, 1'b0, JMP_NEXT, UPC_IDLE);
         5'd3:  w = uw(MUL_AX, 1'b0, MUL_AX, 1'b1, PP_SH32, 1'b0, BASE_ZERO, TERM_PP,
                      WB_NONE, 1'b0, JMP_NEXT, UPC_IDLE);
         5'd4:  w = uw(MUL_AX, 1'b1, MUL_AX, 1'b0, PP_SH32, 1'b0, BASE_ACC,  TERM_PP,
                      WB_NONE, 1'b0, JMP_NEXT, UPC_IDLE);
         5'd5:  w = uw(MUL_AX, 1'b1, MUL_AX, 1'b1, PP_SH64, 1'b0, BASE_ACC,  TERM_PP,
                      WB_NONE, 1'b0, JMP_NEXT, UPC_IDLE);
         // |y|^2
         5'd6:  w = uw(MUL_AY, 1'b0, MUL_AY, 1'b0, PP_SH0,  1'b0, BASE_ACC,  TERM_PP,
                      WB_NONE, 1'b0, JMP_NEXT, UPC_IDLE);
         5'd7:  w = uw(MUL_AY, 1'b0, MUL_AY, 1'b1, PP_SH32, 1'b0, BASE_ZERO, TERM_PP,
                      WB_XX,   1'b0, JMP_NEXT, UPC_IDLE);
         5'd8:  w = uw(MUL_AY, 1'b1, MUL_AY, 1'b0, PP_SH32, 1'b0, BASE_ACC,  TERM_PP,
                      WB_NONE, 1'b0, JMP_NEXT, UPC_IDLE);
         5'd9:  w = uw(MUL_AY, 1'b1, MUL_AY, 1'b1, PP_SH64, 1'b0, BASE_ACC,  TERM_PP,
                      WB_NONE, 1'b0, JMP_NEXT, UPC_IDLE);
         5'd10: w = uw(MUL_AX, 1'b0, MUL_AX, 1'b0, PP_SH0,  1'b0, BASE_ACC,  TERM_PP,
                      WB_NONE, 1'b0, JMP_NEXT, UPC_IDLE);
         // |z|^2 into the accumulator
         5'd11: w = uw(MUL_AX, 1'b0, MUL_AX, 1'b0, PP_SH0,  1'b0, BASE_ZERO, TERM_XX,
                      WB_YY,   1'b0, JMP_NEXT, UPC_IDLE);
         5'd12: w = uw(MUL_AX, 1'b0, MUL_AX, 1'b0, PP_SH0,  1'b0, BASE_ACC,  TERM_YY,
                      WB_NONE, 1'b0, JMP_NEXT, UPC_IDLE);
         5'd13: w = uw(MUL_AX, 1'b0, MUL_AX, 1'b0, PP_SH0,  1'b0, BASE_ACC,  TERM_NONE,
                      WB_NONE, 1'b0, JMP_ESC, UPC_DONE);
         5'd14: w = uw(MUL_AX, 1'b0, MUL_AX, 1'b0, PP_SH0,  1'b0, BASE_ACC,  TERM_NONE,
                      WB_CNT,  1'b0, JMP_NEXT, UPC_IDLE);
         5'd15: w = uw(MUL_AX, 1'b0, MUL_AX, 1'b0, PP_SH0,  1'b0, BASE_ACC,  TERM_NONE,
                      WB_NONE, 1'b1, JMP_CAP, UPC_DONE);
         // x*y + cy/2, signed
         5'd16: w = uw(MUL_AX, 1'b0, MUL_AY, 1'b0, PP_SH0,  1'b1, BASE_ACC,  TERM_NONE,
                      WB_NONE, 1'b0, JMP_NEXT, UPC_IDLE);
         5'd17: w = uw(MUL_AX, 1'b0, MUL_AY, 1'b1, PP_SH32, 1'b1, BASE_CY,   TERM_PP,
                      WB_NONE, 1'b0, JMP_NEXT, UPC_IDLE);
         5'd18: w = uw(MUL_AX, 1'b1, MUL_AY, 1'b0, PP_SH32, 1'b1, BASE_ACC,  TERM_PP,
                      WB_NONE, 1'b0, JMP_NEXT, UPC_IDLE);
         5'd19: w = uw(MUL_AX, 1'b1, MUL_AY, 1'b1, PP_SH64, 1'b1, BASE_ACC,  TERM_PP,
                      WB_NONE, 1'b0, JMP_NEXT, UPC_IDLE);
         5'd20: w = uw(MUL_AX, 1'b0, MUL_AX, 1'b0, PP_SH0,  1'b0, BASE_ACC,  TERM_PP,
                      WB_NONE, 1'b0, JMP_NEXT, UPC_IDLE);
         // x^2 - y^2 + cx
         5'd21: w = uw(MUL_AX, 1'b0, MUL_AX, 1'b0, PP_SH0,  1'b0, BASE_CX,   TERM_XX,
                      WB_Y,    1'b0, JMP_NEXT, UPC_IDLE);
         5'd22: w = uw(MUL_AX, 1'b0, MUL_AX, 1'b0, PP_SH0,  1'b0, BASE_ACC,  TERM_NEG_YY,
                      WB_NONE, 1'b0, JMP_NEXT, UPC_IDLE);
         5'd23: w = uw(MUL_AX, 1'b0, MUL_AX, 1'b0, PP_SH0,  1'b0, BASE_ACC,  TERM_NONE,
                      WB_X,    1'b0, JMP_ALWAYS, UPC_ABS);
         5'd24: w = uw(MUL_AX, 1'b0, MUL_AX, 1'b0, PP_SH0,  1'b0, BASE_ACC,  TERM_NONE,
                      WB_NONE, 1'b0, JMP_OUT, UPC_IDLE);
         default: w = uw(MUL_AX, 1'b0, MUL_AX, 1'b0, PP_SH0, 1'b0, BASE_ACC, TERM_NONE,
                      WB_NONE, 1'b0, JMP_ALWAYS, UPC_IDLE);
      endcase
      return w;
   endfunction

endpackage

[src/efi_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efi_req_if
// Request channel: one complex sample point per beat.
// ----------------------------------------------------------------------------
interface efi_req_if;
   logic               valid;
   logic               ready;
   logic signed [63:0] point_re;
   logic signed [63:0] point_im;

   modport source (output valid, output point_re, output point_im, input ready);
   modport sink (input valid, input point_re, input point_im, output ready);
endinterface

[src/efi_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efi_rsp_if
// Response channel: iteration count, in-set flag and final |z|^2 per beat.
// ----------------------------------------------------------------------------
interface efi_rsp_if #(
   parameter int COUNT_BITS = 20
);
   logic                  valid;
   logic                  ready;
   logic [COUNT_BITS-1:0] iteration_count;
   logic                  in_set;
   logic [63:0]           final_mag_sq;

   modport source (output valid, output iteration_count, output in_set,
                   output final_mag_sq, input ready);
   modport sink (input valid, input iteration_count, input in_set,
                 input final_mag_sq, output ready);
endinterface

[src/efi_useq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efi_useq
// Microcode sequencer: step counter, control store and conditional jumps.
// ----------------------------------------------------------------------------
module efi_useq (
   input  logic                   clock,
   input  logic                   reset,
   input  efi_pkg::seq_status_type status,
   output efi_pkg::ucode_word_type ctrl
);
   import efi_pkg::*;

   upc_type pc_ff;
   upc_type pc_in;
   upc_type pc_next;

   assign ctrl    = ucode_rom(pc_ff);
   assign pc_next = pc_ff + upc_type'(1);

   always_comb begin
      case (ctrl.cond)
         JMP_NEXT:   pc_in = pc_next;
         JMP_ALWAYS: pc_in = ctrl.target;
         JMP_REQ:    pc_in = status.req_valid ? ctrl.target : pc_ff;
         JMP_ESC:    pc_in = status.esc_hit ? ctrl.target : pc_next;
         JMP_CAP:    pc_in = status.cap_hit ? ctrl.target : pc_next;
         JMP_OUT:    pc_in = status.out_free ? ctrl.target : pc_ff;
         default:    pc_in = UPC_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= UPC_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

[src/escape_time_fractal_iterator_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escape_time_fractal_iterator_unit
// Mandelbrot / Julia escape-time iteration in signed Q16.48 fixed point.
// ----------------------------------------------------------------------------
// a run ends when |z|^2 escapes or when the count reaches the cap; the response
//   then waits for the slot to be free
// throughput: one point at a time; each z = z*z + c pass is paced by the
//   single 32x32 multiplier shared over 12 partial products per pass
// the response register frees the datapath while a result waits to be taken
// reset (synchronous, active high) restores register defaults, empties the slot
module escape_time_fractal_iterator_unit #(
   parameter int COUNT_BITS = 20,
   parameter int FRAC_BITS  = 48
) (
   input  logic                  clock,
   input  logic                  reset,
   efi_req_if.sink               req_port,
   efi_rsp_if.source             rsp_port,
   input  logic                  csr_write_en,
   input  efi_pkg::csr_addr_type csr_index,
   input  logic [63:0]           csr_data
);
   import efi_pkg::*;

   localparam int MAG_SHIFT = 2 * FRAC_BITS - 32;

   // configuration registers
   logic                  mode_ff;
   logic [WORD_BITS-1:0]  julia_re_ff;
   logic [WORD_BITS-1:0]  julia_im_ff;
   logic [CAP_BITS-1:0]   cap_cfg_ff;
   logic [LIMIT_BITS-1:0] limit_ff;

   // sequencer
   ucode_word_type ctrl;
   seq_status_type status;

   // datapath
   logic [WORD_BITS-1:0]  x_ff, x_in;
   logic [WORD_BITS-1:0]  y_ff, y_in;
   logic [WORD_BITS-1:0]  cx_ff, cx_in;
   logic [WORD_BITS-1:0]  cy_ff, cy_in;
   logic [WORD_BITS-1:0]  ax_ff, ax_in;
   logic [WORD_BITS-1:0]  ay_ff, ay_in;
   logic [WORD_BITS-1:0]  pp_ff, pp_in;
   pp_shift_type          pp_shift_ff;
   logic                  pp_neg_ff, pp_neg_in;
   logic [ACC_BITS-1:0]   acc_ff, acc_in;
   logic [ACC_BITS-1:0]   xx_ff, xx_in;
   logic [ACC_BITS-1:0]   yy_ff, yy_in;
   logic [COUNT_BITS-1:0] n_ff, n_in;
   logic [COUNT_BITS-1:0] cap_ff, cap_in;
   logic                  iter_ff, iter_in;
   logic                  esc_ff, esc_in;

   // response slot
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COUNT_BITS-1:0] rsp_count_ff, rsp_count_in;
   logic                  rsp_in_set_ff, rsp_in_set_in;
   logic [WORD_BITS-1:0]  rsp_mag_ff, rsp_mag_in;

   logic                  req_take;
   logic                  rsp_load;
   logic                  esc_take;
   logic [COUNT_BITS-1:0] cap_trim;

   logic [WORD_BITS-1:0]  mul_a_word, mul_b_word;
   logic [HALF_BITS-1:0]  mul_a_half, mul_b_half;

   logic [ACC_BITS-1:0]   base_val, term_val, pp_wide, acc_sum;
   logic [ACC_BITS-1:0]   cx_wide, cy_wide;
   logic                  term_sub;

   logic signed [ACC_BITS-1:0] acc_signed, re_shifted, im_shifted;
   logic [WORD_BITS-1:0]  x_sat, y_sat;
   logic [ACC_BITS-1:0]   esc_limit;
   logic [ACC_BITS-1:0]   mag_shifted;
   logic [WORD_BITS-1:0]  mag_q32;

   // ---------------------------------------------------------------------------
   // configuration writes
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_RESET;
         julia_re_ff <= JULIA_RE_RESET;
         julia_im_ff <= JULIA_IM_RESET;
         cap_cfg_ff  <= CAP_RESET;
         limit_ff    <= LIMIT_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_MODE:     mode_ff     <= csr_data[0];
            CSR_JULIA_RE: julia_re_ff <= csr_data;
            CSR_JULIA_IM: julia_im_ff <= csr_data;
            CSR_CAP:      cap_cfg_ff  <= csr_data[CAP_BITS-1:0];
            CSR_LIMIT:    limit_ff    <= csr_data[LIMIT_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------------
   // sequencer and its branch conditions
   // ---------------------------------------------------------------------------
   efi_useq u_useq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   // escape means |z|^2 strictly above the limit (scaled to Q.2F)
   assign esc_limit = ACC_BITS'(limit_ff) << (2 * FRAC_BITS);

   always_comb begin
      status.req_valid = req_port.valid;
      status.out_free  = !rsp_valid_ff || rsp_port.ready;
      // the first |z|^2 (starting point) is never tested for escape
      status.esc_hit   = iter_ff && (acc_ff > esc_limit);
      status.cap_hit   = (n_ff >= cap_ff);
   end

   assign req_port.ready = (ctrl.cond == JMP_REQ);
   assign req_take       = req_port.valid && (ctrl.cond == JMP_REQ);
   assign rsp_load       = (ctrl.cond == JMP_OUT) && status.out_free;
   assign esc_take       = (ctrl.cond == JMP_ESC) && status.esc_hit;

   // a cap of zero behaves as a cap of one
   assign cap_trim = COUNT_BITS'(cap_cfg_ff);

   // ---------------------------------------------------------------------------
   // 32x32 partial-product multiplier on operand magnitudes
   // ---------------------------------------------------------------------------
   always_comb begin
      mul_a_word = (ctrl.mul_a == MUL_AY) ? ay_ff : ax_ff;
      mul_b_word = (ctrl.mul_b == MUL_AY) ? ay_ff : ax_ff;
      mul_a_half = ctrl.mul_a_hi ? mul_a_word[WORD_BITS-1:HALF_BITS]
                                 : mul_a_word[HALF_BITS-1:0];
      mul_b_half = ctrl.mul_b_hi ? mul_b_word[WORD_BITS-1:HALF_BITS]
                                 : mul_b_word[HALF_BITS-1:0];
      pp_in      = WORD_BITS'(mul_a_half) * WORD_BITS'(mul_b_half);
      // x*y takes the sign of the operands; squares stay positive
      pp_neg_in  = ctrl.pp_xy_sign && (x_ff[WORD_BITS-1] ^ y_ff[WORD_BITS-1]);
   end

   // ---------------------------------------------------------------------------
   // 128-bit accumulator: base +/- term
   // ---------------------------------------------------------------------------
   assign cx_wide = {{(ACC_BITS-WORD_BITS){cx_ff[WORD_BITS-1]}}, cx_ff} << FRAC_BITS;
   assign cy_wide = {{(ACC_BITS-WORD_BITS){cy_ff[WORD_BITS-1]}}, cy_ff} << (FRAC_BITS - 1);

   always_comb begin
      case (pp_shift_ff)
         PP_SH0:  pp_wide = ACC_BITS'(pp_ff);
         PP_SH32: pp_wide = ACC_BITS'(pp_ff) << HALF_BITS;
         PP_SH64: pp_wide = ACC_BITS'(pp_ff) << WORD_BITS;
         default: pp_wide = '0;
      endcase

      case (ctrl.acc_base)
         BASE_ZERO: base_val = '0;
         BASE_ACC:  base_val = acc_ff;
         BASE_CX:   base_val = cx_wide;
         BASE_CY:   base_val = cy_wide;
         default:   base_val = '0;
      endcase

      case (ctrl.acc_term)
         TERM_PP: begin
            term_val = pp_wide;
            term_sub = pp_neg_ff;
         end
         TERM_XX: begin
            term_val = xx_ff;
            term_sub = 1'b0;
         end
         TERM_YY: begin
            term_val = yy_ff;
            term_sub = 1'b0;
         end
         TERM_NEG_YY: begin
            term_val = yy_ff;
            term_sub = 1'b1;
         end
         default: begin
            term_val = '0;
            term_sub = 1'b0;
         end
      endcase

      acc_sum = base_val + (term_sub ? ~term_val : term_val) + ACC_BITS'(term_sub);
      acc_in  = (ctrl.acc_term == TERM_NONE) ? acc_ff : acc_sum;
   end

   // ---------------------------------------------------------------------------
   // rescale and saturate new z, unsigned Q32.32 view of |z|^2
   // ---------------------------------------------------------------------------
   always_comb begin
      acc_signed = acc_ff;
      re_shifted = acc_signed >>> FRAC_BITS;
      im_shifted = acc_signed >>> (FRAC_BITS - 1);

      if ((&re_shifted[ACC_BITS-1:WORD_BITS-1]) || !(|re_shifted[ACC_BITS-1:WORD_BITS-1])) begin
         x_sat = re_shifted[WORD_BITS-1:0];
      end else begin
         x_sat = re_shifted[ACC_BITS-1] ? S64_MIN : S64_MAX;
      end

      if ((&im_shifted[ACC_BITS-1:WORD_BITS-1]) || !(|im_shifted[ACC_BITS-1:WORD_BITS-1])) begin
         y_sat = im_shifted[WORD_BITS-1:0];
      end else begin
         y_sat = im_shifted[ACC_BITS-1] ? S64_MIN : S64_MAX;
      end

      // |z|^2 may reach 2^127, so it is read unsigned
      mag_shifted = acc_ff >> MAG_SHIFT;
      mag_q32     = (|mag_shifted[ACC_BITS-1:WORD_BITS]) ? '1 : mag_shifted[WORD_BITS-1:0];
   end

   // ---------------------------------------------------------------------------
   // write-back and point load
   // ---------------------------------------------------------------------------
   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      cx_in   = cx_ff;
      cy_in   = cy_ff;
      ax_in   = ax_ff;
      ay_in   = ay_ff;
      xx_in   = xx_ff;
      yy_in   = yy_ff;
      n_in    = n_ff;
      cap_in  = cap_ff;
      iter_in = iter_ff;
      esc_in  = esc_ff;

      if (req_take) begin
         // julia starts from the swapped point, one iteration already counted
         if (mode_ff == MODE_JULIA) begin
            x_in  = req_port.point_im;
            y_in  = req_port.point_re;
            cx_in = julia_re_ff;
            cy_in = julia_im_ff;
            n_in  = COUNT_BITS'(1);
         end else begin
            x_in  = req_port.point_re;
            y_in  = req_port.point_im;
            cx_in = req_port.point_re;
            cy_in = req_port.point_im;
            n_in  = '0;
         end
         cap_in  = (cap_trim == '0) ? COUNT_BITS'(1) : cap_trim;
         iter_in = 1'b0;
         esc_in  = 1'b0;
      end

      case (ctrl.wb)
         WB_ABS: begin
            ax_in = x_ff[WORD_BITS-1] ? (~x_ff + WORD_BITS'(1)) : x_ff;
            ay_in = y_ff[WORD_BITS-1] ? (~y_ff + WORD_BITS'(1)) : y_ff;
         end
         WB_XX: xx_in = acc_ff;
         WB_YY: yy_in = acc_ff;
         WB_X:  x_in  = x_sat;
         WB_Y:  y_in  = y_sat;
         WB_CNT: begin
            // the count moves only after a pass that did not escape
            if (iter_ff) begin
               n_in = n_ff + COUNT_BITS'(1);
            end
         end
         default: begin
         end
      endcase

      if (ctrl.iter_set) begin
         iter_in = 1'b1;
      end
      if (esc_take) begin
         esc_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      y_ff        <= y_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      ax_ff       <= ax_in;
      ay_ff       <= ay_in;
      pp_ff       <= pp_in;
      pp_shift_ff <= ctrl.pp_shift;
      pp_neg_ff   <= pp_neg_in;
      acc_ff      <= acc_in;
      xx_ff       <= xx_in;
      yy_ff       <= yy_in;
      n_ff        <= n_in;
      cap_ff      <= cap_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iter_ff <= 1'b0;
         esc_ff  <= 1'b0;
      end else begin
         iter_ff <= iter_in;
         esc_ff  <= esc_in;
      end
   end

   // ---------------------------------------------------------------------------
   // response register: loaded at the done step, held until the beat is taken
   // ---------------------------------------------------------------------------
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_in_set_in = rsp_in_set_ff;
      rsp_mag_in    = rsp_mag_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_count_in  = n_ff;
         rsp_in_set_in = !esc_ff;
         rsp_mag_in    = mag_q32;
      end else if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_count_ff  <= rsp_count_in;
      rsp_in_set_ff <= rsp_in_set_in;
      rsp_mag_ff    <= rsp_mag_in;
   end

   assign rsp_port.valid           = rsp_valid_ff;
   assign rsp_port.iteration_count = rsp_count_ff;
   assign rsp_port.in_set          = rsp_in_set_ff;
   assign rsp_port.final_mag_sq    = rsp_mag_ff;

endmodule
